// File: rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// Line time base corrector package
// Payload types, register indexes and reset values that the block's files share.
// ----------------------------------------------------------------------------
`default_nettype none

package tbc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TGT_BITS    = 12;
  localparam int LPF_BITS    = 10;
  localparam int IDX_BITS    = 11;
  localparam int FIELD_BITS  = 16;

  localparam logic [TGT_BITS-1:0] TGT_MIN = 12'd2;
  localparam logic [TGT_BITS-1:0] TGT_MAX = 12'd2048;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYNC_THRESHOLD     = 2'd0;
  localparam logic [1:0] CFG_TARGET_LINE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_LINES_PER_FIELD    = 2'd2;

  // Register reset values
  localparam logic signed [SAMPLE_BITS-1:0] THR_RESET = -16'sd9830;
  localparam logic [TGT_BITS-1:0]           TGT_RESET = 12'd910;
  localparam logic [LPF_BITS-1:0]           LPF_RESET = 10'd262;

  // Input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] corrected_sample;
    logic [IDX_BITS-1:0]           sample_index;
    logic [LPF_BITS-1:0]           line_in_field;
    logic [FIELD_BITS-1:0]         field_number;
    logic                          last_of_line;
    logic                          last_of_field;
    logic                          line_truncated;
    logic                          line_dropped;
  } out_t;

  // Divider handshake status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/tbc_div.sv
// ----------------------------------------------------------------------------
// Line time base corrector ratio divider
// Restoring divider, one quotient bit a cycle, for the per-line step ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_div #(
  parameter int NW = 27,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] numer,
  input  wire logic [DW-1:0] denom,
  output tbc_pkg::div_stat_t stat,
  output      logic [NW-1:0] quot
);
  import tbc_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   num_r, num_nxt;
  logic [DW-1:0]   den_r;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DW:0]     rem_sh;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem_r, num_r[NW-1]};
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = numer;
      rem_nxt  = '0;
      cnt_nxt  = CNTW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DW'(rem_sh - {1'b0, den_r});
        num_nxt = {num_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DW-1:0];
        num_nxt = {num_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold operands; no reset needed
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= denom;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = num_r;

endmodule

`default_nettype wire

// File: rtl/video_line_time_base_corrector_top.sv
// ----------------------------------------------------------------------------
// Video line time base corrector
// Splits a sample stream into lines at sync edges and replays each line
// linearly resampled to a fixed length.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per item; opcode 0 pushes a sample, opcode 1 is a
//           drain tick. in_stall is high while an item is in work.
//   out_* : one transfer per tick that finds a line draining.
//   cfg_* : register writes, taken whenever cfg_we is high; write only idle.
// Flow:
//   Samples stream at one per clock while in_stall is low.
//   A sample that closes a line while no line drains stalls the input
//   until the step ratio divider, which yields one quotient bit a cycle,
//   has formed its NW = log2(MAX_LINE_SAMPLES) + FRACTION_BITS bits.
//   A drain tick passes store read, interpolation multiply, sum and
//   output load, each registered, before the result appears on out_*.
// Reset clears all control state; the line store holds no reset value.
// A stalled result holds in the output register; the next item is still
// taken, and a tick waits in its last stage until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module video_line_time_base_corrector_top #(
  parameter int MAX_LINE_SAMPLES = 2048,
  parameter int FRACTION_BITS    = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire tbc_pkg::in_t                   in_data,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      tbc_pkg::out_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [tbc_pkg::SAMPLE_BITS-1:0] cfg_wdata
);
  import tbc_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int F    = FRACTION_BITS;
  localparam int CW   = $clog2(MAX_LINE_SAMPLES);
  localparam int WCW  = CW + 1;
  localparam int AW   = CW + 1;
  localparam int NW   = CW + F;
  localparam int DW   = TGT_BITS - 1;
  localparam int PW   = SB + F + 2;
  localparam int DEPTH = 2 * MAX_LINE_SAMPLES;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic signed [SB-1:0] thr_r;
  logic [TGT_BITS-1:0]  tgt_cfg_r;
  logic [LPF_BITS-1:0]  lpf_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_RESET;
      tgt_cfg_r <= TGT_RESET;
      lpf_cfg_r <= LPF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_THRESHOLD:     thr_r     <= cfg_wdata;
        CFG_TARGET_LINE_LENGTH: tgt_cfg_r <= cfg_wdata[TGT_BITS-1:0];
        CFG_LINES_PER_FIELD:    lpf_cfg_r <= cfg_wdata[LPF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Line state
  logic                 bank_r, bank_nxt;
  logic [WCW-1:0]       wcnt_r, wcnt_nxt;
  logic signed [SB-1:0] prev_r;
  logic                 have_prev_r;
  logic                 seen_r, seen_nxt;
  logic                 drain_r, drain_nxt;
  logic [WCW-1:0]       dlen_r, dlen_nxt;
  logic [TGT_BITS-1:0]  dtgt_r, dtgt_nxt;
  logic                 dtrunc_r, dtrunc_nxt;
  logic                 ddrop_r, ddrop_nxt;
  logic [NW-1:0]        step_r, step_nxt;
  logic [NW-1:0]        rpos_r, rpos_nxt;
  logic [IDX_BITS-1:0]  oidx_r, oidx_nxt;
  logic [LPF_BITS-1:0]  lcnt_r, lcnt_nxt;
  logic [FIELD_BITS-1:0] fcnt_r, fcnt_nxt;
  logic [1:0]           pend_r, pend_nxt;

  // Tick pipeline
  logic                 use_b_r, use_b_nxt;
  logic [F-1:0]         frac_r, frac_nxt;
  out_t                 meta_r, meta_nxt;
  logic signed [SB-1:0] rda_r, rdb_r;
  logic signed [SB-1:0] a_r;
  logic signed [PW-1:0] prod_r;
  logic signed [SB-1:0] val_r;
  logic                 out_valid_r;
  out_t                 out_r;

  // Memory access
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr_a, rd_addr_b;

  // Divider
  logic          div_start;
  logic [NW-1:0] div_numer;
  logic [DW-1:0] div_denom;
  div_stat_t     div_stat;
  logic [NW-1:0] div_quot;

  logic                 acc;
  logic                 edge_det;
  logic [TGT_BITS-1:0]  tgt_clamp;
  logic [LPF_BITS-1:0]  lpf_eff;
  logic [CW-1:0]        idx;
  logic [WCW-1:0]       len_eff;
  logic [WCW-1:0]       idx_clamp;
  logic                 last_line;
  logic                 last_field;
  logic                 out_free;
  logic signed [SB:0]   diff;
  logic signed [PW-1:0] a_sh;
  logic signed [PW-1:0] sum;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign edge_det = have_prev_r && (in_data.sample_value < thr_r) && (prev_r >= thr_r);

  always_comb begin
    tgt_clamp = tgt_cfg_r;
    if (tgt_cfg_r < TGT_MIN) tgt_clamp = TGT_MIN;
    if (tgt_cfg_r > TGT_MAX) tgt_clamp = TGT_MAX;
  end

  assign lpf_eff = (lpf_cfg_r == '0) ? LPF_BITS'(1) : lpf_cfg_r;

  // Read position split into store index and fraction, index held inside the line
  assign idx     = rpos_r[NW-1:F];
  assign len_eff = (dlen_r == '0) ? WCW'(1) : dlen_r;
  assign idx_clamp = ({1'b0, idx} >= len_eff) ? len_eff - 1'b1 : {1'b0, idx};

  assign last_line  = ({1'b0, oidx_r} + 1'b1) >= dtgt_r;
  assign last_field = last_line && (({1'b0, lcnt_r} + 1'b1) >= {1'b0, lpf_eff});

  // Main control: push, line end, tick issue and counter update
  always_comb begin
    state_nxt  = state_r;
    bank_nxt   = bank_r;
    wcnt_nxt   = wcnt_r;
    seen_nxt   = seen_r;
    drain_nxt  = drain_r;
    dlen_nxt   = dlen_r;
    dtgt_nxt   = dtgt_r;
    dtrunc_nxt = dtrunc_r;
    ddrop_nxt  = ddrop_r;
    step_nxt   = step_r;
    rpos_nxt   = rpos_r;
    oidx_nxt   = oidx_r;
    lcnt_nxt   = lcnt_r;
    fcnt_nxt   = fcnt_r;
    pend_nxt   = pend_r;
    use_b_nxt  = use_b_r;
    frac_nxt   = frac_r;
    meta_nxt   = meta_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr_a  = {~bank_r, idx_clamp[CW-1:0]};
    rd_addr_b  = {~bank_r, CW'(idx_clamp + 1'b1)};
    div_start  = 1'b0;
    div_numer  = NW'({dlen_r[CW-1:0] - 1'b1, {F{1'b0}}});
    div_denom  = DW'(dtgt_r - 1'b1);

    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_data.opcode == OP_SAMPLE) begin
          // Close the line at a sync edge
          if (edge_det && seen_r) begin
            if (drain_r) begin
              pend_nxt[0] = 1'b1;
            end else begin
              dtgt_nxt   = tgt_clamp;
              dlen_nxt   = wcnt_r;
              dtrunc_nxt = pend_r[1];
              ddrop_nxt  = pend_r[0];
              pend_nxt[0] = 1'b0;
              bank_nxt   = ~bank_r;
              drain_nxt  = 1'b1;
              rpos_nxt   = '0;
              oidx_nxt   = '0;
              div_start  = 1'b1;
              div_numer  = (wcnt_r == '0) ? '0 : NW'({wcnt_r[CW-1:0] - 1'b1, {F{1'b0}}});
              div_denom  = DW'(tgt_clamp - 1'b1);
              state_nxt  = ST_DIV;
            end
            wcnt_nxt    = '0;
            pend_nxt[1] = 1'b0;
          end
          if (edge_det) seen_nxt = 1'b1;
          // Store the sample, or flag the line as cut
          if (seen_nxt) begin
            if (wcnt_nxt < WCW'(MAX_LINE_SAMPLES)) begin
              wr_en    = 1'b1;
              wr_addr  = {bank_nxt, wcnt_nxt[CW-1:0]};
              wcnt_nxt = wcnt_nxt + 1'b1;
            end else begin
              pend_nxt[1] = 1'b1;
            end
          end
        end else if (acc && drain_r) begin
          // Issue the store reads and advance the drain
          rd_en     = 1'b1;
          use_b_nxt = (idx_clamp + 1'b1) < len_eff;
          frac_nxt  = rpos_r[F-1:0];
          meta_nxt.corrected_sample = '0;
          meta_nxt.sample_index     = oidx_r;
          meta_nxt.line_in_field    = lcnt_r;
          meta_nxt.field_number     = fcnt_r;
          meta_nxt.last_of_line     = last_line;
          meta_nxt.last_of_field    = last_field;
          meta_nxt.line_truncated   = dtrunc_r;
          meta_nxt.line_dropped     = ddrop_r;
          if (last_line) begin
            drain_nxt = 1'b0;
            oidx_nxt  = '0;
            rpos_nxt  = '0;
            if (last_field) begin
              lcnt_nxt = '0;
              fcnt_nxt = fcnt_r + 1'b1;
            end else begin
              lcnt_nxt = lcnt_r + 1'b1;
            end
          end else begin
            oidx_nxt = oidx_r + 1'b1;
            rpos_nxt = rpos_r + step_r;
          end
          state_nxt = ST_RD;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          step_nxt  = div_quot;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD:  state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      wcnt_r      <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      seen_r      <= 1'b0;
      drain_r     <= 1'b0;
      dlen_r      <= '0;
      dtgt_r      <= '0;
      dtrunc_r    <= 1'b0;
      ddrop_r     <= 1'b0;
      step_r      <= '0;
      rpos_r      <= '0;
      oidx_r      <= '0;
      lcnt_r      <= '0;
      fcnt_r      <= '0;
      pend_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      bank_r   <= bank_nxt;
      wcnt_r   <= wcnt_nxt;
      seen_r   <= seen_nxt;
      drain_r  <= drain_nxt;
      dlen_r   <= dlen_nxt;
      dtgt_r   <= dtgt_nxt;
      dtrunc_r <= dtrunc_nxt;
      ddrop_r  <= ddrop_nxt;
      step_r   <= step_nxt;
      rpos_r   <= rpos_nxt;
      oidx_r   <= oidx_nxt;
      lcnt_r   <= lcnt_nxt;
      fcnt_r   <= fcnt_nxt;
      pend_r   <= pend_nxt;
      if (acc && in_data.opcode == OP_SAMPLE) begin
        prev_r      <= in_data.sample_value;
        have_prev_r <= 1'b1;
      end
    end
  end

  // Line store: two banks, one write and two registered reads per cycle
  logic signed [SB-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_data.sample_value;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rda_r <= mem[rd_addr_a];
      rdb_r <= mem[rd_addr_b];
    end
  end

  // Interpolate: a * 2^F + (b - a) * f, rounded half up
  assign diff = use_b_r ? ({rdb_r[SB-1], rdb_r} - {rda_r[SB-1], rda_r}) : '0;
  assign a_sh = {{(PW-SB-F){a_r[SB-1]}}, a_r, {F{1'b0}}};
  assign sum  = a_sh + prod_r + (PW'(1) <<< (F - 1));

  always_ff @(posedge clk) begin
    use_b_r <= use_b_nxt;
    frac_r  <= frac_nxt;
    meta_r  <= meta_nxt;
    if (state_r == ST_RD) begin
      a_r    <= rda_r;
      prod_r <= diff * $signed({1'b0, frac_r});
    end
    if (state_r == ST_MUL) val_r <= sum[F+SB-1:F];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_r                  <= meta_r;
      out_r.corrected_sample <= val_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  tbc_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .stat  (div_stat),
    .quot  (div_quot)
  );

endmodule

`default_nettype wire

// File: rtl/tbc_chk.sv
// ----------------------------------------------------------------------------
// Line time base corrector port checker
// Watches the top level's ports and flags result sequences that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire tbc_pkg::out_t out_data
);
  import tbc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A field ends only on the final sample of a line
  a_field_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_field |-> out_data.last_of_line)
    else $error("field end without line end");

  // Reset empties the output register and opens the input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result present or input stalled after reset");

  // A sample that follows a non-final one in the same line counts up by one
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_line ##1 out_valid |->
      out_data.sample_index == $past(out_data.sample_index) + 11'd1)
    else $error("sample index skipped");

endmodule

bind video_line_time_base_corrector_top tbc_chk u_tbc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Line time base corrector testbench
// Drives samples and drain ticks through the valid/stall handshake, predicts
// each corrected sample with a bit-accurate model of the line store and the
// linear resampler, and checks every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import tbc_pkg::*;

  localparam int MAXS        = 2048;
  localparam int FRAC        = 16;
  localparam int LIMIT       = 2000000;
  localparam int DIR_ROWS    = 22;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [SAMPLE_BITS-1:0] cfg_wdata = '0;

  video_line_time_base_corrector_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Predictor state
  logic signed [15:0] line_mem [0:2*MAXS-1];
  logic        wr_bank, have_prev, synced, draining, drop_pend, trunc_pend;
  int unsigned wr_count, dr_len, dr_target, out_idx, line_cnt, field_cnt;
  logic signed [15:0] prev_smp;
  logic        dr_trunc, dr_drop;
  longint unsigned ratio, rd_pos;
  logic signed [15:0] thr_reg;
  logic [11:0] tgt_reg;
  logic [9:0]  lpf_reg;

  out_t expected_q[$];
  bit   failed = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_cnt = 0;
  int   cycles = 0;

  task automatic close_line();
    int unsigned t;
    if (draining) begin
      drop_pend = 1'b1;
    end else begin
      t = tgt_reg;
      if (t < 2) t = 2;
      if (t > 2048) t = 2048;
      dr_target = t;
      dr_len = wr_count;
      ratio = (dr_len > 0) ? ((longint'(dr_len - 1)) << FRAC) / (t - 1) : 0;
      dr_trunc = trunc_pend;
      dr_drop = drop_pend;
      drop_pend = 1'b0;
      wr_bank ^= 1'b1;
      draining = 1'b1;
      rd_pos = 0;
      out_idx = 0;
    end
    wr_count = 0;
    trunc_pend = 1'b0;
  endtask

  // Advance the predictor by one accepted item
  task automatic predict_item(in_t it);
    logic signed [15:0] s;
    longint unsigned idx, fr;
    int unsigned len, lpf, base;
    longint signed a, b, sum;
    logic signed [15:0] v;
    bit lastl, lastf;
    out_t r;
    if (it.opcode == OP_SAMPLE) begin
      s = it.sample_value;
      if (have_prev && s < thr_reg && prev_smp >= thr_reg) begin
        if (synced) close_line();
        synced = 1'b1;
      end
      if (synced) begin
        if (wr_count < MAXS) begin
          line_mem[wr_bank * MAXS + wr_count] = s;
          wr_count++;
        end else begin
          trunc_pend = 1'b1;
        end
      end
      prev_smp = s;
      have_prev = 1'b1;
      return;
    end
    if (!draining) return;
    base = (wr_bank ^ 1'b1) * MAXS;
    idx = rd_pos >> FRAC;
    fr = rd_pos & ((64'd1 << FRAC) - 1);
    len = (dr_len == 0) ? 1 : dr_len;
    if (idx >= len) idx = len - 1;
    if (idx + 1 < len) begin
      a = line_mem[base + idx];
      b = line_mem[base + idx + 1];
      sum = a * longint'((64'd1 << FRAC) - fr) + b * longint'(fr);
      v = 16'((sum + (64'sd1 << (FRAC - 1))) >>> FRAC);
    end else begin
      v = line_mem[base + idx];
    end
    lpf = (lpf_reg == 0) ? 1 : lpf_reg;
    lastl = (out_idx + 1) >= dr_target;
    lastf = lastl && (line_cnt + 1) >= lpf;
    r.corrected_sample = v;
    r.sample_index = out_idx[10:0];
    r.line_in_field = line_cnt[9:0];
    r.field_number = field_cnt[15:0];
    r.last_of_line = lastl;
    r.last_of_field = lastf;
    r.line_truncated = dr_trunc;
    r.line_dropped = dr_drop;
    expected_q = {expected_q, r};
    if (lastl) begin
      draining = 1'b0;
      out_idx = 0;
      rd_pos = 0;
      if (lastf) begin
        line_cnt = 0;
        field_cnt = (field_cnt + 1) & 16'hFFFF;
      end else begin
        line_cnt = (line_cnt + 1) & 10'h3FF;
      end
    end else begin
      out_idx++;
      rd_pos += ratio;
    end
  endtask

  // Check results as they are transferred
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        failed = 1'b1;
      end else begin
        out_t e;
        e = expected_q.pop_front();
        if (e !== out_data) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          failed = 1'b1;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off counted here
  always @(posedge clk) begin
    int n;
    n = $urandom_range(0, 99);
    if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt = hold_cnt + 1;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
    end else if (cycles % 600 < 200) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (n < 30);
    end
  end

  // Directed rows: opcode, value, whether an output is typed in, and its
  // corrected sample (with the other fields taken from the predictor)
  in_t         dir_in  [DIR_ROWS];
  logic        dir_chk [DIR_ROWS];
  logic [15:0] dir_val [DIR_ROWS];

  task automatic send(in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
  endtask

  task automatic idle_in();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] ix, logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (ix)
      CFG_SYNC_THRESHOLD:     thr_reg = d;
      CFG_TARGET_LINE_LENGTH: tgt_reg = d[11:0];
      CFG_LINES_PER_FIELD:    lpf_reg = d[9:0];
      default: ;
    endcase
  endtask

  function automatic in_t mk(logic op, logic [15:0] v);
    in_t t;
    t.opcode = op;
    t.sample_value = v;
    return t;
  endfunction

  // Random line with a sync edge up front; some are noise or long
  task automatic rand_line(int len, int ticks);
    int k;
    send(mk(OP_SAMPLE, 16'h7FFF));
    send(mk(OP_SAMPLE, 16'h8000));
    for (k = 1; k < len; k++) begin
      if (k % 2 == 0 && ticks > 0) begin
        send(mk(OP_TICK, 16'($urandom())));
        ticks--;
      end
      if ($urandom_range(0, 7) == 0) idle_in();
      send(mk(OP_SAMPLE, 16'($urandom_range(0, 65535)) | 16'h0 ));
    end
    while (ticks > 0) begin
      send(mk(OP_TICK, 16'($urandom())));
      ticks--;
    end
  endtask

  initial begin
    int i, n, burst, ln, sent;
    wr_bank = 0; have_prev = 0; synced = 0; draining = 0;
    drop_pend = 0; trunc_pend = 0; wr_count = 0; dr_len = 0; dr_target = 0;
    out_idx = 0; line_cnt = 0; field_cnt = 0; prev_smp = 0;
    dr_trunc = 0; dr_drop = 0; ratio = 0; rd_pos = 0;
    thr_reg = THR_RESET; tgt_reg = TGT_RESET; lpf_reg = LPF_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tick with nothing draining, extremes, short lines
    write_reg(CFG_TARGET_LINE_LENGTH, 16'd0);
    write_reg(CFG_LINES_PER_FIELD, 16'd0);
    write_reg(CFG_SYNC_THRESHOLD, 16'h0000);
    dir_in = '{mk(OP_TICK, 16'h0), mk(OP_SAMPLE, 16'h8000), mk(OP_SAMPLE, 16'h7FFF),
               mk(OP_SAMPLE, 16'h8000), mk(OP_SAMPLE, 16'h7FFF), mk(OP_SAMPLE, 16'h0001),
               mk(OP_SAMPLE, 16'hFFFF), mk(OP_TICK, 16'hFFFF), mk(OP_TICK, 16'h0),
               mk(OP_TICK, 16'h0), mk(OP_SAMPLE, 16'h0000), mk(OP_SAMPLE, 16'h8000),
               mk(OP_SAMPLE, 16'h1234), mk(OP_SAMPLE, 16'hFFFF), mk(OP_TICK, 16'h0),
               mk(OP_TICK, 16'h0), mk(OP_SAMPLE, 16'h5555), mk(OP_SAMPLE, 16'hAAAA),
               mk(OP_SAMPLE, 16'h7FFF), mk(OP_SAMPLE, 16'h8001), mk(OP_TICK, 16'h0),
               mk(OP_TICK, 16'h0)};
    for (i = 0; i < DIR_ROWS; i++) begin
      dir_chk[i] = 1'b0;
      dir_val[i] = '0;
    end
    // Ends of each short line read straight from the store
    dir_chk[7]  = 1'b1; dir_val[7]  = 16'h8000;
    dir_chk[8]  = 1'b1; dir_val[8]  = 16'h0001;
    dir_chk[14] = 1'b1; dir_val[14] = 16'hFFFF;
    dir_chk[15] = 1'b1; dir_val[15] = 16'h0000;
    dir_chk[20] = 1'b1; dir_val[20] = 16'hFFFF;
    dir_chk[21] = 1'b1; dir_val[21] = 16'h5555;
    for (i = 0; i < DIR_ROWS; i++) begin
      send(dir_in[i]);
      if (dir_chk[i])
        expected_q[expected_q.size() - 1].corrected_sample = dir_val[i];
    end
    drain_all();

    // Smallest target, then a line that ends while another drains
    write_reg(CFG_TARGET_LINE_LENGTH, 16'd1);
    write_reg(CFG_LINES_PER_FIELD, 16'd1023);
    write_reg(CFG_SYNC_THRESHOLD, 16'h8001);
    rand_line(6, 2);
    rand_line(5, 1);
    rand_line(3, 0);
    for (i = 0; i < 4; i++) send(mk(OP_TICK, 16'h0));
    drain_all();

    // Random phases with varied settings; long hold-off in the first
    sent = 0;
    for (n = 0; sent < 1100; n++) begin
      write_reg(CFG_TARGET_LINE_LENGTH, 16'($urandom_range(1, 24)));
      write_reg(CFG_LINES_PER_FIELD, 16'($urandom_range(1, 4)));
      write_reg(CFG_SYNC_THRESHOLD, (n % 3 == 0) ? 16'h7FFF : 16'h8001);
      if (n == 0) hold_req = 1'b1;
      for (i = 0; i < 8; i++) begin
        ln = $urandom_range(1, 20);
        burst = $urandom_range(0, 24);
        if ($urandom_range(0, 9) == 0) begin
          send(mk(OP_SAMPLE, 16'($urandom())));
          sent++;
        end
        rand_line(ln, burst);
        sent += ln + burst + 1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) idle_in();
      end
      for (i = 0; i < 30; i++) send(mk(OP_TICK, 16'h0));
      sent += 30;
      drain_all();
    end
    write_reg(CFG_SYNC_THRESHOLD, THR_RESET);
    write_reg(CFG_TARGET_LINE_LENGTH, TGT_RESET);
    write_reg(CFG_LINES_PER_FIELD, LPF_RESET);
    rand_line(30, 0);
    rand_line(2, 0);
    for (i = 0; i < 40; i++) send(mk(OP_TICK, 16'h0));
    drain_all();

    if (failed) begin
      $display("tb: failure");
    end else begin
      $display("tb: success");
    end
    $finish;
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

`default_nettype wire
